// ----- hw/rtl/desu_pkg.sv -----
// ============================================================================
// DER signature unpacker package
// Shared constants, codes and types for the DER to raw r||s unpacker.
// ============================================================================
package desu_pkg;

    // Bytes of one integer (r or s) in the raw image
    localparam int INT_BYTES = 32;
    localparam int SIG_BYTES = 2 * INT_BYTES;
    localparam int ADDR_W    = $clog2(SIG_BYTES);
    localparam int INDEX_W   = 6;
    localparam int LEN_W     = 7;
    localparam int SIG_CNT_W = $clog2(INT_BYTES + 1);
    localparam int COUNT_W   = 8;

    localparam logic [7:0]         TAG_SEQUENCE = 8'h30;
    localparam logic [7:0]         TAG_INTEGER  = 8'h02;
    localparam logic [COUNT_W-1:0] MIN_BUFFER   = 8'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

    typedef enum logic [3:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_R_TAG,
        PH_R_LEN,
        PH_R_VAL,
        PH_S_TAG,
        PH_S_LEN,
        PH_S_VAL,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_TAG,
        ST_LONGFORM,
        ST_OVERRUN,
        ST_INTTAG,
        ST_INTLEN,
        ST_TOOLONG
    } status_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } finish_t;

endpackage

// ----- hw/rtl/desu_parser.sv -----
// ============================================================================
// DER signature parser
// Input register plus the per-byte DER state update and end-of-buffer status.
// ============================================================================
module desu_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [7:0]          der_byte,
    input  logic                final_byte,
    output logic                pending_final,
    output desu_pkg::store_wr_t wr,
    output desu_pkg::finish_t   fin
);
    import desu_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 final_reg;

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [LEN_W-1:0]     seq_length_reg, seq_length_next;
    logic [LEN_W-1:0]     seq_left_reg, seq_left_next;
    logic [LEN_W-1:0]     int_left_reg, int_left_next;
    logic [SIG_CNT_W-1:0] sig_count_reg, sig_count_next;
    status_t              first_error_reg, first_error_next;

    logic [LEN_W-1:0]     seq_left_dec;
    logic [LEN_W-1:0]     int_left_dec;
    logic [ADDR_W-1:0]    base_addr;
    logic                 fault;
    logic [COUNT_W:0]     room;
    status_t              end_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= der_byte;
            final_reg <= final_byte;
        end
    end

    assign pending_final = in_valid_reg & final_reg;
    assign seq_left_dec  = (seq_left_reg != '0) ? seq_left_reg - 1'b1 : seq_left_reg;
    assign int_left_dec  = (int_left_reg != '0) ? int_left_reg - 1'b1 : int_left_reg;
    assign base_addr     = (phase_reg == PH_S_VAL) ? ADDR_W'(INT_BYTES) : '0;

    // Per-byte update
    always_comb
    begin
        phase_next       = phase_reg;
        seq_length_next  = seq_length_reg;
        seq_left_next    = seq_left_reg;
        int_left_next    = int_left_reg;
        sig_count_next   = sig_count_reg;
        first_error_next = first_error_reg;
        byte_count_next  = byte_count_reg;
        fault            = 1'b0;
        wr.en            = 1'b0;
        wr.addr          = base_addr + ADDR_W'(INT_BYTES) - ADDR_W'(int_left_reg);
        wr.data          = byte_reg;

        if (in_valid_reg)
        begin
            if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end

            case (phase_reg)
                PH_SEQ_TAG:
                begin
                    if (byte_reg != TAG_SEQUENCE)
                    begin
                        first_error_next = ST_TAG;
                        phase_next       = PH_FAIL;
                    end
                    else
                    begin
                        phase_next = PH_SEQ_LEN;
                    end
                end
                PH_SEQ_LEN:
                begin
                    if (byte_reg[7])
                    begin
                        first_error_next = ST_LONGFORM;
                        phase_next       = PH_FAIL;
                    end
                    else
                    begin
                        seq_length_next = byte_reg[LEN_W-1:0];
                        seq_left_next   = byte_reg[LEN_W-1:0];
                        if (byte_reg[LEN_W-1:0] == '0)
                        begin
                            first_error_next = ST_INTTAG;
                            phase_next       = PH_FAIL;
                        end
                        else
                        begin
                            phase_next = PH_R_TAG;
                        end
                    end
                end
                PH_R_TAG, PH_S_TAG:
                begin
                    seq_left_next = seq_left_dec;
                    if (byte_reg != TAG_INTEGER)
                    begin
                        first_error_next = ST_INTTAG;
                        phase_next       = PH_FAIL;
                    end
                    else if (seq_left_dec == '0)
                    begin
                        first_error_next = ST_INTLEN;
                        phase_next       = PH_FAIL;
                    end
                    else
                    begin
                        phase_next = (phase_reg == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
                    end
                end
                PH_R_LEN, PH_S_LEN:
                begin
                    seq_left_next = seq_left_dec;
                    if (byte_reg == 8'h00 || byte_reg > {1'b0, seq_left_dec})
                    begin
                        first_error_next = ST_INTLEN;
                        phase_next       = PH_FAIL;
                    end
                    else
                    begin
                        int_left_next  = byte_reg[LEN_W-1:0];
                        sig_count_next = '0;
                        phase_next     = (phase_reg == PH_R_LEN) ? PH_R_VAL : PH_S_VAL;
                    end
                end
                PH_R_VAL, PH_S_VAL:
                begin
                    seq_left_next = seq_left_dec;
                    int_left_next = int_left_dec;
                    // Leading zeros are dropped until the first significant byte
                    if (sig_count_reg != '0 || byte_reg != 8'h00)
                    begin
                        if (int_left_reg > LEN_W'(INT_BYTES) || int_left_reg == '0)
                        begin
                            fault            = 1'b1;
                            first_error_next = ST_TOOLONG;
                            phase_next       = PH_FAIL;
                        end
                        else
                        begin
                            wr.en          = 1'b1;
                            sig_count_next = sig_count_reg + 1'b1;
                        end
                    end
                    if (!fault && int_left_dec == '0)
                    begin
                        if (phase_reg == PH_S_VAL)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (seq_left_dec == '0)
                        begin
                            first_error_next = ST_INTTAG;
                            phase_next       = PH_FAIL;
                        end
                        else
                        begin
                            phase_next = PH_S_TAG;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // End-of-buffer status in priority order
    assign room = {1'b0, byte_count_next} - (COUNT_W + 1)'(2);

    always_comb
    begin
        if (byte_count_next < MIN_BUFFER)
        begin
            end_status = ST_SHORT;
        end
        else if (first_error_next == ST_TAG || first_error_next == ST_LONGFORM)
        begin
            end_status = first_error_next;
        end
        else if ((COUNT_W + 1)'(seq_length_next) > room)
        begin
            end_status = ST_OVERRUN;
        end
        else if (first_error_next != ST_OK)
        begin
            end_status = first_error_next;
        end
        else if (phase_next != PH_DONE)
        begin
            end_status = ST_OVERRUN;
        end
        else
        begin
            end_status = ST_OK;
        end
    end

    assign fin.valid  = pending_final;
    assign fin.status = end_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SEQ_TAG;
            byte_count_reg  <= '0;
            seq_length_reg  <= '0;
            seq_left_reg    <= '0;
            int_left_reg    <= '0;
            sig_count_reg   <= '0;
            first_error_reg <= ST_OK;
        end
        else if (pending_final)
        begin
            phase_reg       <= PH_SEQ_TAG;
            byte_count_reg  <= '0;
            seq_length_reg  <= '0;
            seq_left_reg    <= '0;
            int_left_reg    <= '0;
            sig_count_reg   <= '0;
            first_error_reg <= ST_OK;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            seq_length_reg  <= seq_length_next;
            seq_left_reg    <= seq_left_next;
            int_left_reg    <= int_left_next;
            sig_count_reg   <= sig_count_next;
            first_error_reg <= first_error_next;
        end
    end

endmodule

// ----- hw/rtl/desu_store.sv -----
// ============================================================================
// Raw signature store
// r||s image memory with per-entry valid bits; unwritten entries read as zero.
// ============================================================================
module desu_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  desu_pkg::store_wr_t           wr,
    input  logic                          clear,
    input  logic                          rd_en,
    input  logic [desu_pkg::ADDR_W-1:0]   rd_addr,
    output logic [7:0]                    rd_byte
);
    import desu_pkg::*;

    logic [7:0]           mem [SIG_BYTES];
    logic [SIG_BYTES-1:0] valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_keep_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Drop all entries at once at the end of a signature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_keep_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_keep_reg <= rd_en & valid_reg[rd_addr];
        end
    end

    assign rd_byte = rd_keep_reg ? rd_data_reg : 8'h00;

endmodule

// ----- hw/rtl/der_ecdsa_signature_unpacker_unit.sv -----
// ============================================================================
// DER ECDSA signature unpacker
// Turns a DER SEQUENCE { INTEGER r, INTEGER s } into the raw r||s image.
// ============================================================================
// Usage:
//   Input: drive der_byte and final_byte with start high; a byte transfers at
//   a rising edge where start is high and busy is low. Raise final_byte on the
//   last byte of the buffer.
//   Output: each result is shown for exactly one cycle with result_strobe high;
//   the receiver cannot stall it.
//   Throughput: one byte per cycle while a signature streams in. The final
//   byte holds busy high while it is parsed.
//   Results: an error item passes the parser's input register and the result
//   register on its way to the result ports. On success the store is read out
//   one byte per cycle through its single read port: 64 results, the last
//   with run_end set, each through the store's read register. busy stays high
//   from the final byte transfer through the readout, so the next signature
//   may start right after the readout.
//   Reset: the parser returns to waiting for the sequence tag, the store reads
//   as all zero, and no result is pending.
// ============================================================================
module der_ecdsa_signature_unpacker_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] der_byte,
    input  logic       final_byte,
    output logic       result_strobe,
    output logic [7:0] sig_byte,
    output logic [5:0] byte_index,
    output logic [2:0] status,
    output logic       run_end
);
    import desu_pkg::*;

    logic              accept;
    logic              pending_final;
    store_wr_t         wr;
    finish_t           fin;
    logic              clear;
    logic              last_read;

    logic              drain_active_reg, drain_active_next;
    logic [ADDR_W-1:0] drain_idx_reg, drain_idx_next;
    logic              strobe_reg, strobe_next;
    logic              run_end_reg, run_end_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    status_t           status_reg, status_next;

    // Hold off new bytes while the final byte is parsed and during readout
    assign busy   = drain_active_reg | pending_final;
    assign accept = start & ~busy;

    desu_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .der_byte      (der_byte),
        .final_byte    (final_byte),
        .pending_final (pending_final),
        .wr            (wr),
        .fin           (fin)
    );

    assign last_read = drain_active_reg && (drain_idx_reg == ADDR_W'(SIG_BYTES - 1));
    // Drop the image after an error or once the last byte has been read
    assign clear     = (fin.valid && fin.status != ST_OK) || last_read;

    desu_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .clear   (clear),
        .rd_en   (drain_active_reg),
        .rd_addr (drain_idx_reg),
        .rd_byte (sig_byte)
    );

    // Readout sequencer and result register
    always_comb
    begin
        drain_active_next = drain_active_reg;
        drain_idx_next    = drain_idx_reg;
        strobe_next       = 1'b0;
        run_end_next      = 1'b0;
        index_next        = '0;
        status_next       = ST_OK;

        if (drain_active_reg)
        begin
            // Advance one entry per cycle; the store registers the read data
            strobe_next    = 1'b1;
            index_next     = INDEX_W'(drain_idx_reg);
            run_end_next   = last_read;
            drain_idx_next = drain_idx_reg + 1'b1;
            if (last_read)
            begin
                drain_active_next = 1'b0;
                drain_idx_next    = '0;
            end
        end
        else if (fin.valid)
        begin
            if (fin.status == ST_OK)
            begin
                drain_active_next = 1'b1;
                drain_idx_next    = '0;
            end
            else
            begin
                // Single error item closes the run
                strobe_next  = 1'b1;
                run_end_next = 1'b1;
                status_next  = fin.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_active_reg <= 1'b0;
            drain_idx_reg    <= '0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            drain_active_reg <= drain_active_next;
            drain_idx_reg    <= drain_idx_next;
            strobe_reg       <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_end_reg <= run_end_next;
        index_reg   <= index_next;
        status_reg  <= status_next;
    end

    assign result_strobe = strobe_reg;
    assign byte_index    = index_reg;
    assign status        = status_reg;
    assign run_end       = run_end_reg;

endmodule

// ----- hw/rtl/desu_checker.sv -----
// ============================================================================
// DER signature unpacker checker
// Port-level checks on the result stream of the unpacker.
// ============================================================================
module desu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       busy,
    input logic       result_strobe,
    input logic [7:0] sig_byte,
    input logic [5:0] byte_index,
    input logic [2:0] status,
    input logic       run_end
);
    import desu_pkg::*;

    // An error run is one item, all zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && status != 3'(ST_OK))
            |-> (run_end && sig_byte == 8'h00 && byte_index == '0))
        else $error("error item not a lone zero item");

    // A success run streams without gaps until run_end
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !run_end) |=> result_strobe)
        else $error("gap in result run");

    // Success items count up by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !run_end)
            |=> (byte_index == 6'($past(byte_index) + 6'd1) && status == 3'(ST_OK)))
        else $error("result index out of order");

    // No new transfer may be taken in the middle of a readout
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !run_end) |-> busy)
        else $error("not busy during readout");

endmodule

bind der_ecdsa_signature_unpacker_unit desu_checker u_desu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .result_strobe (result_strobe),
    .sig_byte      (sig_byte),
    .byte_index    (byte_index),
    .status        (status),
    .run_end       (run_end)
);

// ----- dv/der_ecdsa_signature_unpacker_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// DER ECDSA signature unpacker testbench
// Streams DER encoded signatures into the unpacker one byte per transfer and
// checks every result against a cycle-free model of the parser that is kept
// in a small scoreboard. A short directed set covers each status code. A
// random set follows until the byte budget is spent: mostly well-formed
// signatures with random content, the rest corrupted, truncated or noise.
// ============================================================================
module der_ecdsa_signature_unpacker_unit_tb;

    import desu_pkg::*;

    // Input bytes to send over the whole run
    localparam int BYTE_BUDGET = 120;

    // One raw r||s byte, or one error item
    typedef struct {
        logic [7:0]         value;
        logic [INDEX_W-1:0] index;
        status_t            code;
        logic               last;
    } raw_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: parses the accepted bytes the way the unpacker does and
    // queues the raw image, or the error item, on every final byte.
    // ------------------------------------------------------------------------
    class sig_scoreboard;
        phase_t               ph;
        logic [COUNT_W-1:0]   nbytes;
        logic [LEN_W-1:0]     seq_len;
        logic [7:0]           seq_rem;
        logic [7:0]           int_rem;
        logic [SIG_CNT_W-1:0] sig_seen;
        status_t              fault;
        logic [7:0]           image [SIG_BYTES];
        raw_item_t            expected_q[$];
        int                   errors;
        int                   frames;
        int                   decoded;
        bit [7:0]             status_mask;

        function new();
            errors      = 0;
            frames      = 0;
            decoded     = 0;
            status_mask = '0;
            clear();
        endfunction

        function void clear();
            ph       = PH_SEQ_TAG;
            nbytes   = '0;
            seq_len  = '0;
            seq_rem  = '0;
            int_rem  = '0;
            sig_seen = '0;
            fault    = ST_OK;
            foreach (image[i])
                image[i] = 8'h00;
        endfunction

        function void raise_fault(status_t code);
            fault = code;
            ph    = PH_FAIL;
        endfunction

        // Enter an integer tag phase; the sequence must still hold a byte
        function void open_tag(phase_t next_ph);
            ph = next_ph;
            if (seq_rem == 8'd0)
                raise_fault(ST_INTTAG);
        endfunction

        function void parse(logic [7:0] b);
            logic [7:0] k;
            int         base;
            case (ph)
                PH_SEQ_TAG:
                    if (b != TAG_SEQUENCE)
                        raise_fault(ST_TAG);
                    else
                        ph = PH_SEQ_LEN;
                PH_SEQ_LEN:
                begin
                    if (b[7])
                        raise_fault(ST_LONGFORM);
                    else
                    begin
                        seq_len = b[6:0];
                        seq_rem = {1'b0, b[6:0]};
                        open_tag(PH_R_TAG);
                    end
                end
                PH_R_TAG, PH_S_TAG:
                begin
                    if (seq_rem != 8'd0)
                        seq_rem = seq_rem - 8'd1;
                    if (b != TAG_INTEGER)
                        raise_fault(ST_INTTAG);
                    else
                    begin
                        ph = (ph == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
                        if (seq_rem == 8'd0)
                            raise_fault(ST_INTLEN);
                    end
                end
                PH_R_LEN, PH_S_LEN:
                begin
                    if (seq_rem != 8'd0)
                        seq_rem = seq_rem - 8'd1;
                    if (b == 8'd0 || b > seq_rem)
                        raise_fault(ST_INTLEN);
                    else
                    begin
                        int_rem  = b;
                        sig_seen = '0;
                        ph       = (ph == PH_R_LEN) ? PH_R_VAL : PH_S_VAL;
                    end
                end
                PH_R_VAL, PH_S_VAL:
                begin
                    k    = int_rem;
                    base = (ph == PH_R_VAL) ? 0 : INT_BYTES;
                    if (seq_rem != 8'd0)
                        seq_rem = seq_rem - 8'd1;
                    if (int_rem != 8'd0)
                        int_rem = int_rem - 8'd1;
                    // Leading zeros are dropped; a significant byte lands right-aligned
                    if (sig_seen != '0 || b != 8'd0)
                    begin
                        if (int'(k) > INT_BYTES || k == 8'd0)
                        begin
                            raise_fault(ST_TOOLONG);
                            return;
                        end
                        image[base + INT_BYTES - int'(k)] = b;
                        sig_seen = sig_seen + 1'b1;
                    end
                    if (int_rem == 8'd0)
                    begin
                        if (ph == PH_R_VAL)
                            open_tag(PH_S_TAG);
                        else
                            ph = PH_DONE;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        // A short buffer outranks every parser fault; an overrun outranks all but a tag or long-form fault
        function status_t final_status();
            if (nbytes < MIN_BUFFER)
                return ST_SHORT;
            if (fault == ST_TAG || fault == ST_LONGFORM)
                return fault;
            if ({1'b0, seq_len} > nbytes - 8'd2)
                return ST_OVERRUN;
            if (fault != ST_OK)
                return fault;
            if (ph != PH_DONE)
                return ST_OVERRUN;
            return ST_OK;
        endfunction

        function void note_input(logic [7:0] b, logic fin);
            status_t   st;
            raw_item_t item;
            if (nbytes != COUNT_MAX)
                nbytes = nbytes + 1'b1;
            parse(b);
            if (!fin)
                return;
            st = final_status();
            frames++;
            status_mask[st] = 1'b1;
            if (st != ST_OK)
            begin
                item.value = 8'h00;
                item.index = '0;
                item.code  = st;
                item.last  = 1'b1;
                expected_q.push_back(item);
            end
            else
            begin
                decoded++;
                for (int i = 0; i < SIG_BYTES; i++)
                begin
                    item.value = image[i];
                    item.index = INDEX_W'(i);
                    item.code  = ST_OK;
                    item.last  = (i == SIG_BYTES - 1);
                    expected_q.push_back(item);
                end
            end
            clear();
        endfunction

        // One line per mismatch, counted
        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_result(logic [7:0] value, logic [INDEX_W-1:0] index,
                          logic [2:0] code, logic last);
            raw_item_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result byte=%02h index=%0d status=%0d run_end=%b",
                                 value, index, code, last));
                return;
            end
            exp = expected_q.pop_front();
            if (value !== exp.value || index !== exp.index || code !== exp.code
                || last !== exp.last)
                report($sformatf("got byte=%02h index=%0d status=%0d run_end=%b, exp %02h %0d %0d %b",
                                 value, index, code, last,
                                 exp.value, exp.index, exp.code, exp.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       start      = 1'b0;
    logic [7:0] der_byte   = 8'h00;
    logic       final_byte = 1'b0;
    logic       busy;
    logic       result_strobe;
    logic [7:0] sig_byte;
    logic [5:0] byte_index;
    logic [2:0] status;
    logic       run_end;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    der_ecdsa_signature_unpacker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .der_byte      (der_byte),
        .final_byte    (final_byte),
        .result_strobe (result_strobe),
        .sig_byte      (sig_byte),
        .byte_index    (byte_index),
        .status        (status),
        .run_end       (run_end)
    );

    sig_scoreboard sb;
    logic [7:0]    frame_q[$];
    logic [7:0]    body_q[$];
    bit            gaps_on   = 1'b1;
    int            bytes_sent = 0;

    // Sample both sides at the rising edge, before any update of this edge lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_input(der_byte, final_byte);
            if (result_strobe)
                sb.check_result(sig_byte, byte_index, status, run_end);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one byte and hold it until it transfers; returns on the
    // accepting edge so the next byte can follow back to back.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        der_byte   <= b;
        final_byte <= fin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send the whole frame, marking its last byte as final
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Append one INTEGER: leading zeros, then nsig bytes with a nonzero head
    task automatic push_int(input int nsig, input int nzero);
        body_q.push_back(TAG_INTEGER);
        body_q.push_back(8'(nsig + nzero));
        repeat (nzero) body_q.push_back(8'h00);
        for (int i = 0; i < nsig; i++)
            body_q.push_back(i == 0 ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255)));
    endtask

    // Build a well-formed SEQUENCE, with optional padding inside and after it
    task automatic build_frame(input int r_sig, input int r_zero, input int s_sig,
                               input int s_zero, input int inner_pad, input int outer_pad);
        body_q.delete();
        push_int(r_sig, r_zero);
        push_int(s_sig, s_zero);
        repeat (inner_pad) body_q.push_back(8'($urandom_range(0, 255)));
        frame_q.delete();
        frame_q.push_back(TAG_SEQUENCE);
        frame_q.push_back(8'(body_q.size()));
        foreach (body_q[i])
            frame_q.push_back(body_q[i]);
        repeat (outer_pad) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Mostly short integers; now and then the full width or one byte too many
    function automatic int pick_sig();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return INT_BYTES;
        if (sel == 1)
            return INT_BYTES + 1;
        return $urandom_range(0, 8);
    endfunction

    // An all-zero integer still needs at least one byte
    function automatic int pick_zeros(input int nsig);
        if (nsig == 0)
            return $urandom_range(1, 3);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic random_frame(input bit broken);
        int r_sig;
        int s_sig;
        int n;
        r_sig = pick_sig();
        s_sig = pick_sig();
        build_frame(r_sig, pick_zeros(r_sig), s_sig, pick_zeros(s_sig),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        if (broken)
        begin
            case ($urandom_range(0, 3))
                0:
                    // Overwrite one byte anywhere
                    frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
                1:
                begin
                    // End the buffer early
                    n = $urandom_range(1, frame_q.size());
                    while (frame_q.size() > n)
                        void'(frame_q.pop_back());
                end
                2:
                begin
                    // Pure noise
                    frame_q.delete();
                    repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom_range(0, 255)));
                end
                default:
                    // Random sequence length, long form included
                    frame_q[1] = 8'($urandom_range(0, 255));
            endcase
        end
        send_frame();
    endtask

    task automatic run_directed();
        // Smallest valid signature
        frame_q = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h7F};
        send_frame();
        // Short buffer of seven bytes
        frame_q = '{8'h30, 8'h05, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01};
        send_frame();
        // Wrong sequence tag
        frame_q = '{8'h31, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
        send_frame();
        // Long-form length
        frame_q = '{8'h30, 8'h81, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
        send_frame();
        // Declared length past the buffer
        frame_q = '{8'h30, 8'h7F, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
        send_frame();
        // Wrong integer tag on s
        frame_q = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h04, 8'h01, 8'h01};
        send_frame();
        // Integer length longer than the sequence holds
        frame_q = '{8'h30, 8'h06, 8'h02, 8'h05, 8'h01, 8'h02, 8'h01, 8'h01};
        send_frame();
        // Too many significant bytes in r
        build_frame(INT_BYTES + 1, 0, 1, 0, 0, 0);
        send_frame();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int guard;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random frames until the budget is spent; no idle bursts near the end
        while (bytes_sent < BYTE_BUDGET)
        begin
            gaps_on = (bytes_sent < BYTE_BUDGET - 24);
            random_frame($urandom_range(0, 9) < 3);
        end
        start <= 1'b0;

        // Drain: wait for the outstanding results, then keep the clock running before the summary
        guard = 0;
        while (sb.expected_q.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));

        $display("Ran %0d signatures over %0d byte transfers: %0d decoded, %0d rejected",
                 sb.frames, bytes_sent, sb.decoded, sb.frames - sb.decoded);
        $display("Status codes seen (bit per code): %b, mismatches: %0d",
                 sb.status_mask, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
